>>> design/onewire_temperature_reader_assert.svh
// ----------------------------------------------------------------------------
// onewire temperature reader assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMPERATURE_READER_ASSERT_SVH
`define ONEWIRE_TEMPERATURE_READER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OWT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define OWT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/owt_pkg.sv
// ----------------------------------------------------------------------------
// owt_pkg
// shared constants, types and helpers of the 1-wire temperature reader
// ----------------------------------------------------------------------------
package owt_pkg;

	// timer reach of the slot and phase counters
	localparam int unsigned TIMER_BITS = 16;
	localparam int unsigned TIMER_MAX  = (1 << TIMER_BITS) - 1;

	// configuration port shape
	localparam int unsigned CFG_ADDR_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 16;

	// register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_READ_ENABLE    = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_RESET_LOW      = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_PRESENCE_WAIT  = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_RESET_RECOVER  = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_WRITE_SLOT     = 3'd4;
	localparam logic [CFG_ADDR_BITS-1:0] REG_READ_SAMPLE    = 3'd5;
	localparam logic [CFG_ADDR_BITS-1:0] REG_READ_RECOVER   = 3'd6;
	localparam logic [CFG_ADDR_BITS-1:0] REG_CONVERT_WAIT   = 3'd7;

	// 1-wire command bytes
	localparam logic [7:0] CMD_SKIP_ROM   = 8'hcc;
	localparam logic [7:0] CMD_CONVERT    = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hbe;

	// stream widths
	localparam int unsigned IN_DATA_BITS  = 8;
	localparam int unsigned OUT_DATA_BITS = 24;

	// effective timing limits seen by the sequencer
	typedef struct packed {
		logic                  read_enable;
		logic [TIMER_BITS-1:0] reset_low;
		logic [TIMER_BITS-1:0] presence_wait;
		logic [TIMER_BITS-1:0] reset_recover;
		logic [TIMER_BITS-1:0] write_slot;
		logic [TIMER_BITS-1:0] read_sample;
		logic [TIMER_BITS-1:0] read_recover;
		logic [TIMER_BITS-1:0] convert_wait;
	} cfg_t;

	// one result word
	typedef struct packed {
		logic        temp_negative;
		logic [11:0] temp_integer;
		logic        presence_missing;
		logic        done_res;
		logic        busy_res;
		logic        drive_low;
	} res_t;

	// zero counts as one, values past the timer reach saturate
	function automatic logic [TIMER_BITS-1:0] eff_limit(input logic [CFG_DATA_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w > 32'(TIMER_MAX))
			w = 32'(TIMER_MAX);
		if (w == 32'd0)
			w = 32'd1;
		return TIMER_BITS'(w);
	endfunction

endpackage

>>> design/owt_cfg.sv
// ----------------------------------------------------------------------------
// owt_cfg
// configuration register file with effective timing limits
// ----------------------------------------------------------------------------
module owt_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [owt_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [owt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output owt_pkg::cfg_t                      cfg
);
	import owt_pkg::*;

	logic                     read_enable_q;
	logic [CFG_DATA_BITS-1:0] reset_low_q;
	logic [CFG_DATA_BITS-1:0] presence_wait_q;
	logic [CFG_DATA_BITS-1:0] reset_recover_q;
	logic [CFG_DATA_BITS-1:0] write_slot_q;
	logic [CFG_DATA_BITS-1:0] read_sample_q;
	logic [CFG_DATA_BITS-1:0] read_recover_q;
	logic [CFG_DATA_BITS-1:0] convert_wait_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_enable_q   <= 1'b0;
			reset_low_q     <= 16'd600;
			presence_wait_q <= 16'd30;
			reset_recover_q <= 16'd600;
			write_slot_q    <= 16'd30;
			read_sample_q   <= 16'd6;
			read_recover_q  <= 16'd24;
			convert_wait_q  <= 16'd300;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_READ_ENABLE:   read_enable_q   <= cfg_wdata[0];
				REG_RESET_LOW:     reset_low_q     <= cfg_wdata;
				REG_PRESENCE_WAIT: presence_wait_q <= cfg_wdata;
				REG_RESET_RECOVER: reset_recover_q <= cfg_wdata;
				REG_WRITE_SLOT:    write_slot_q    <= cfg_wdata;
				REG_READ_SAMPLE:   read_sample_q   <= cfg_wdata;
				REG_READ_RECOVER:  read_recover_q  <= cfg_wdata;
				REG_CONVERT_WAIT:  convert_wait_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamped limits
	always_comb begin
		cfg.read_enable   = read_enable_q;
		cfg.reset_low     = eff_limit(reset_low_q);
		cfg.presence_wait = eff_limit(presence_wait_q);
		cfg.reset_recover = eff_limit(reset_recover_q);
		cfg.write_slot    = eff_limit(write_slot_q);
		cfg.read_sample   = eff_limit(read_sample_q);
		cfg.read_recover  = eff_limit(read_recover_q);
		cfg.convert_wait  = eff_limit(convert_wait_q);
	end

endmodule

>>> design/owt_core.sv
// ----------------------------------------------------------------------------
// owt_core
// 1-wire sequencer state, advanced by one tick per step
// ----------------------------------------------------------------------------
module owt_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          start_req,
	input  logic          line_in,
	input  owt_pkg::cfg_t cfg,
	output owt_pkg::res_t res
);
	import owt_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_REC,
		PH_WR_START,
		PH_WR_HOLD,
		PH_WR_REC,
		PH_CONV,
		PH_RD_START,
		PH_RD_WAIT,
		PH_RD_REC
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] tick_q, tick_d;
	logic [2:0]            bit_q, bit_d;
	logic [2:0]            byte_step_q, byte_step_d;
	logic [7:0]            shift_q, shift_d;
	logic [7:0]            raw_low_q, raw_low_d;
	logic [11:0]           result_int_q, result_int_d;
	logic                  result_neg_q, result_neg_d;
	logic                  presence_q, presence_d;

	phase_t                ph;
	logic [TIMER_BITS-1:0] tick_cur;
	logic [TIMER_BITS-1:0] lim;
	logic [TIMER_BITS:0]   tick_inc;
	logic                  t_end;
	logic [TIMER_BITS-1:0] tick_adv;
	logic [15:0]           raw;
	logic [15:0]           mag;
	logic                  drive, busy, done;

	// next state for one tick
	always_comb begin
		ph       = phase_q;
		tick_cur = tick_q;
		byte_step_d = byte_step_q;
		if (phase_q == PH_IDLE && start_req && cfg.read_enable) begin
			ph          = PH_RST_LOW;
			tick_cur    = '0;
			byte_step_d = 3'd0;
		end
		busy = (ph != PH_IDLE);

		// limit of the timed phase, and its end test
		case (ph)
			PH_RST_LOW:  lim = cfg.reset_low;
			PH_RST_WAIT: lim = cfg.presence_wait;
			PH_RST_REC:  lim = cfg.reset_recover;
			PH_WR_HOLD:  lim = cfg.write_slot;
			PH_CONV:     lim = cfg.convert_wait;
			PH_RD_WAIT:  lim = cfg.read_sample;
			PH_RD_REC:   lim = cfg.read_recover;
			default:     lim = cfg.reset_low;
		endcase
		tick_inc = {1'b0, tick_cur} + 1'b1;
		t_end    = (tick_inc >= {1'b0, lim});
		tick_adv = t_end ? '0 : tick_inc[TIMER_BITS-1:0];

		// temperature from the two bytes read
		raw = {shift_q, raw_low_q};
		mag = shift_q[7] ? (16'd0 - raw) : raw;

		phase_d      = ph;
		tick_d       = tick_cur;
		bit_d        = bit_q;
		shift_d      = shift_q;
		raw_low_d    = raw_low_q;
		result_int_d = result_int_q;
		result_neg_d = result_neg_q;
		presence_d   = presence_q;
		drive        = 1'b0;
		done         = 1'b0;

		case (ph)
			PH_IDLE: ;
			PH_RST_LOW: begin
				drive  = 1'b1;
				tick_d = tick_adv;
				if (t_end)
					phase_d = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				tick_d = tick_adv;
				if (t_end) begin
					presence_d = line_in;
					phase_d    = PH_RST_REC;
				end
			end
			PH_RST_REC: begin
				tick_d = tick_adv;
				if (t_end) begin
					byte_step_d = (byte_step_q == 3'd2) ? 3'd3 : 3'd0;
					shift_d     = CMD_SKIP_ROM;
					bit_d       = 3'd0;
					tick_d      = '0;
					phase_d     = PH_WR_START;
				end
			end
			PH_WR_START: begin
				drive   = 1'b1;
				tick_d  = '0;
				phase_d = PH_WR_HOLD;
			end
			PH_WR_HOLD: begin
				drive  = ~shift_q[0];
				tick_d = tick_adv;
				if (t_end)
					phase_d = PH_WR_REC;
			end
			PH_WR_REC: begin
				shift_d = {1'b0, shift_q[7:1]};
				tick_d  = '0;
				if (bit_q < 3'd7) begin
					bit_d   = bit_q + 3'd1;
					phase_d = PH_WR_START;
				end else if (byte_step_q == 3'd0) begin
					byte_step_d = 3'd1;
					shift_d     = CMD_CONVERT;
					bit_d       = 3'd0;
					phase_d     = PH_WR_START;
				end else if (byte_step_q == 3'd1) begin
					byte_step_d = 3'd2;
					phase_d     = PH_CONV;
				end else if (byte_step_q == 3'd3) begin
					byte_step_d = 3'd4;
					shift_d     = CMD_READ_SCRATCH;
					bit_d       = 3'd0;
					phase_d     = PH_WR_START;
				end else begin
					byte_step_d = 3'd5;
					shift_d     = 8'd0;
					bit_d       = 3'd0;
					phase_d     = PH_RD_START;
				end
			end
			PH_CONV: begin
				tick_d = tick_adv;
				if (t_end)
					phase_d = PH_RST_LOW;
			end
			PH_RD_START: begin
				drive   = 1'b1;
				tick_d  = '0;
				phase_d = PH_RD_WAIT;
			end
			PH_RD_WAIT: begin
				tick_d = tick_adv;
				if (t_end) begin
					shift_d = {line_in, shift_q[7:1]};
					phase_d = PH_RD_REC;
				end
			end
			PH_RD_REC: begin
				tick_d = tick_adv;
				if (t_end) begin
					if (bit_q < 3'd7) begin
						bit_d   = bit_q + 3'd1;
						phase_d = PH_RD_START;
					end else if (byte_step_q == 3'd5) begin
						raw_low_d   = shift_q;
						byte_step_d = 3'd6;
						shift_d     = 8'd0;
						bit_d       = 3'd0;
						phase_d     = PH_RD_START;
					end else begin
						result_neg_d = shift_q[7];
						result_int_d = mag[15:4];
						done         = 1'b1;
						phase_d      = PH_IDLE;
						bit_d        = 3'd0;
						byte_step_d  = 3'd0;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		endcase

		res.drive_low        = drive;
		res.busy_res         = busy;
		res.done_res         = done;
		res.presence_missing = presence_d;
		res.temp_integer     = result_int_d;
		res.temp_negative    = result_neg_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_q       <= '0;
			bit_q        <= 3'd0;
			byte_step_q  <= 3'd0;
			shift_q      <= 8'd0;
			raw_low_q    <= 8'd0;
			result_int_q <= 12'd0;
			result_neg_q <= 1'b0;
			presence_q   <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			tick_q       <= tick_d;
			bit_q        <= bit_d;
			byte_step_q  <= byte_step_d;
			shift_q      <= shift_d;
			raw_low_q    <= raw_low_d;
			result_int_q <= result_int_d;
			result_neg_q <= result_neg_d;
			presence_q   <= presence_d;
		end
	end

endmodule

>>> design/onewire_temperature_reader.sv
// ----------------------------------------------------------------------------
// onewire_temperature_reader
// 1-wire master that reads one temperature sensor per start request
// ----------------------------------------------------------------------------
// Each input word is one microsecond tick: start_req and the sampled bus
// level line_in. Each accepted word gives exactly one result word with the
// line drive for that tick, busy, done, presence status and the last
// temperature as sign and integer magnitude.
// A word is registered at the input, then stepped through the sequencer into
// the output register once that register is free or being read, and its
// result shows on m_tvalid. One word is taken per cycle while m_tready holds;
// the figure is set by the single-tick step of the phase/slot sequencer.
// When the receiver stalls, the result waits in the output register, one
// more word waits in the input register, and s_tready then drops until
// m_tready returns. The cfg port writes timing registers at once; write it
// only while no sequence runs.
// Reset clears the sequencer to idle, empties both registers, and loads the
// default timings with reads disabled.
// ----------------------------------------------------------------------------
module onewire_temperature_reader (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side, tdata: start_req, line_in, zero padding
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [owt_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// master side, tdata: drive_low, busy_res, done_res, presence_missing,
	// temp_integer[11:0], temp_negative, zero padding
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [owt_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [owt_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [owt_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import owt_pkg::*;

	cfg_t cfg;
	res_t res;

	logic       valid_s1;
	logic       start_s1;
	logic       line_s1;
	logic       out_valid_q;
	res_t       out_q;
	logic       advance;

	owt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// step the sequencer when the input stage can move into the output
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	owt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.start_req (start_s1),
		.line_in   (line_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tdata[0];
			line_s1  <= s_tdata[1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.temp_negative, out_q.temp_integer,
		out_q.presence_missing, out_q.done_res, out_q.busy_res, out_q.drive_low};

endmodule

>>> design/owt_checker.sv
// ----------------------------------------------------------------------------
// owt_checker
// port-level checks of the temperature reader, bound to the top level
// ----------------------------------------------------------------------------
`include "onewire_temperature_reader_assert.svh"

module owt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [owt_pkg::OUT_DATA_BITS-1:0] m_tdata
);
	import owt_pkg::*;

	// a stalled result holds
	`OWT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// input only stalls while a result waits
	`OWT_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result waiting")

	// the bus is only driven during a sequence
	`OWT_ASSERT_NOW(a_drive_busy, m_tvalid && m_tdata[0], m_tdata[1], "line driven while not busy")

	// done is the last tick of a sequence
	`OWT_ASSERT_NOW(a_done_busy, m_tvalid && m_tdata[2], m_tdata[1] && !m_tdata[0], "done outside a sequence")

endmodule

bind onewire_temperature_reader owt_checker u_owt_checker (.*);

>>> sim/tb_onewire_temperature_reader.sv
// ----------------------------------------------------------------------------
// tb_onewire_temperature_reader
// stream-level test of the 1-wire temperature reader
// ----------------------------------------------------------------------------
// An initial block turns a scripted bus history into tick words: a simulated
// sensor answers presence and returns chosen scratchpad bytes. A shadow
// sequencer in this file predicts the result word of every tick. A clocked
// driver presents the words, and a clocked monitor compares each result word
// field by field with the oldest prediction. The run covers disabled reads,
// directed temperatures at the shortest timings, then random reads and noise
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_onewire_temperature_reader;
	timeunit 1ns;
	timeprecision 1ps;

	import owt_pkg::*;

	// shadow sequencer states
	typedef enum logic [4:0] {
		ST_IDLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_REC, ST_WR_START, ST_WR_HOLD,
		ST_WR_REC, ST_CONV, ST_RD_START, ST_RD_WAIT, ST_RD_REC
	} seq_state_t;

	// command byte progress through one read
	localparam logic [2:0] STEP_SKIP1 = 3'd0;
	localparam logic [2:0] STEP_CONV  = 3'd1;
	localparam logic [2:0] STEP_WAIT  = 3'd2;
	localparam logic [2:0] STEP_SKIP2 = 3'd3;
	localparam logic [2:0] STEP_RDCMD = 3'd4;
	localparam logic [2:0] STEP_RD_LO = 3'd5;
	localparam logic [2:0] STEP_RD_HI = 3'd6;

	typedef struct {
		logic start;
		logic line;
		res_t due;
	} bus_tick_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     cfg_we    = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	bus_tick_t ticks_to_send[$];
	res_t      bus_results_due[$];
	bus_tick_t nxt;
	res_t      on_bus;
	int        send_gap_pct   = 0;
	int        recv_stall_pct = 0;
	int        mismatches     = 0;

	// shadow registers and sequencer state, reset values
	logic [15:0] cfg_shadow [8] = '{16'd0, 16'd600, 16'd30, 16'd600,
		16'd30, 16'd6, 16'd24, 16'd300};
	seq_state_t  st     = ST_IDLE;
	logic [15:0] tcount = '0;
	logic [2:0]  bcount = '0;
	logic [2:0]  bstep  = STEP_SKIP1;
	logic [7:0]  sbyte  = '0;
	logic [7:0]  raw_lo = '0;
	logic [11:0] t_int  = '0;
	logic        t_neg  = 1'b0;
	logic        pres   = 1'b0;

	onewire_temperature_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// counts one tick of a timed phase, true on its last tick
	function automatic logic slot_done(input logic [15:0] setting);
		logic [15:0] lim;
		lim = (setting == 16'd0) ? 16'd1 : setting;
		if ({1'b0, tcount} + 17'd1 >= {1'b0, lim}) begin
			tcount = '0;
			return 1'b1;
		end
		tcount = tcount + 16'd1;
		return 1'b0;
	endfunction

	function automatic void load_shift(input logic [7:0] b, input seq_state_t go);
		sbyte  = b;
		bcount = '0;
		tcount = '0;
		st     = go;
	endfunction

	// one bus tick of the master: drive level, flags and last temperature
	function automatic res_t master_tick(input logic start, input logic line);
		res_t        r;
		logic [15:0] word;
		r = '0;
		if (st == ST_IDLE && start && cfg_shadow[REG_READ_ENABLE][0]) begin
			st     = ST_RST_LOW;
			tcount = '0;
			bstep  = STEP_SKIP1;
		end
		r.busy_res = (st != ST_IDLE);
		case (st)
			ST_RST_LOW: begin
				r.drive_low = 1'b1;
				if (slot_done(cfg_shadow[REG_RESET_LOW]))
					st = ST_RST_WAIT;
			end
			ST_RST_WAIT: begin
				if (slot_done(cfg_shadow[REG_PRESENCE_WAIT])) begin
					pres = line;
					st   = ST_RST_REC;
				end
			end
			ST_RST_REC: begin
				if (slot_done(cfg_shadow[REG_RESET_RECOVER])) begin
					bstep = (bstep == STEP_WAIT) ? STEP_SKIP2 : STEP_SKIP1;
					load_shift(CMD_SKIP_ROM, ST_WR_START);
				end
			end
			ST_WR_START: begin
				r.drive_low = 1'b1;
				tcount      = '0;
				st          = ST_WR_HOLD;
			end
			ST_WR_HOLD: begin
				r.drive_low = ~sbyte[0];
				if (slot_done(cfg_shadow[REG_WRITE_SLOT]))
					st = ST_WR_REC;
			end
			ST_WR_REC: begin
				sbyte  = sbyte >> 1;
				tcount = '0;
				if (bcount < 3'd7) begin
					bcount = bcount + 3'd1;
					st     = ST_WR_START;
				end else if (bstep == STEP_SKIP1) begin
					bstep = STEP_CONV;
					load_shift(CMD_CONVERT, ST_WR_START);
				end else if (bstep == STEP_CONV) begin
					bstep = STEP_WAIT;
					st    = ST_CONV;
				end else if (bstep == STEP_SKIP2) begin
					bstep = STEP_RDCMD;
					load_shift(CMD_READ_SCRATCH, ST_WR_START);
				end else begin
					bstep = STEP_RD_LO;
					load_shift(8'h00, ST_RD_START);
				end
			end
			ST_CONV: begin
				if (slot_done(cfg_shadow[REG_CONVERT_WAIT]))
					st = ST_RST_LOW;
			end
			ST_RD_START: begin
				r.drive_low = 1'b1;
				tcount      = '0;
				st          = ST_RD_WAIT;
			end
			ST_RD_WAIT: begin
				if (slot_done(cfg_shadow[REG_READ_SAMPLE])) begin
					sbyte = {line, sbyte[7:1]};
					st    = ST_RD_REC;
				end
			end
			ST_RD_REC: begin
				if (slot_done(cfg_shadow[REG_READ_RECOVER])) begin
					if (bcount < 3'd7) begin
						bcount = bcount + 3'd1;
						st     = ST_RD_START;
					end else if (bstep == STEP_RD_LO) begin
						raw_lo = sbyte;
						bstep  = STEP_RD_HI;
						load_shift(8'h00, ST_RD_START);
					end else begin
						// sign and magnitude of the 16-bit reading
						word  = {sbyte, raw_lo};
						t_neg = sbyte[7];
						if (t_neg)
							word = -word;
						t_int       = word[15:4];
						r.done_res  = 1'b1;
						st          = ST_IDLE;
						tcount      = '0;
						bcount      = '0;
						bstep       = STEP_SKIP1;
					end
				end
			end
			default: begin
			end
		endcase
		r.presence_missing = pres;
		r.temp_integer     = t_int;
		r.temp_negative    = t_neg;
		return r;
	endfunction

	task automatic push_tick(input logic start, input logic line);
		bus_tick_t t;
		t.start = start;
		t.line  = line;
		t.due   = master_tick(start, line);
		ticks_to_send.push_back(t);
	endtask

	// wait until every queued word is sent and every result word is back
	task automatic settle();
		while (ticks_to_send.size() != 0 || s_tvalid || bus_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		cfg_shadow[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one read with a simulated sensor answering, or a noisy line
	task automatic run_read(input logic [15:0] raw, input logic sensor_here,
		input logic noisy, input logic hold_at_conv);
		logic ln;
		logic held;
		held = 1'b0;
		push_tick(1'b1, 1'($urandom_range(1)));
		while (st != ST_IDLE) begin
			if (noisy)
				ln = 1'($urandom_range(1));
			else begin
				case (st)
					ST_RST_WAIT: ln = ~sensor_here;
					ST_RD_START, ST_RD_WAIT, ST_RD_REC: ln = raw[{bstep == STEP_RD_HI, bcount}];
					default: ln = 1'b1;
				endcase
			end
			if (hold_at_conv && !held && st == ST_CONV) begin
				settle();
				held = 1'b1;
			end
			push_tick($urandom_range(3) == 0, ln);
		end
	endtask

	// sender: present queued tick words, random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				bus_results_due.push_back(on_bus);
			if (!s_tvalid || s_tready) begin
				if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt      = ticks_to_send.pop_front();
					on_bus   = nxt.due;
					s_tvalid <= 1'b1;
					s_tdata  <= IN_DATA_BITS'({nxt.line, nxt.start});
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// receiver: random stalls, compare each result word
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[$bits(res_t)-1:0]);
				if (bus_results_due.size() == 0) begin
					$error("result word with none expected: %h", m_tdata);
					mismatches++;
				end else begin
					want = bus_results_due.pop_front();
					check_field("drive_low", want.drive_low, got.drive_low);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("presence_missing", want.presence_missing, got.presence_missing);
					check_field("temp_integer", want.temp_integer, got.temp_integer);
					check_field("temp_negative", want.temp_negative, got.temp_negative);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int          p;
		int          k;
		logic [15:0] raw;
		logic [15:0] picks [6];
		picks = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h07d0, 16'hfc90};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads disabled: start requests are ignored, both line levels
		push_tick(1'b1, 1'b0);
		push_tick(1'b1, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);
		settle();

		// shortest timings, zero counts as one
		write_reg(REG_READ_ENABLE, 16'h0001);
		for (k = REG_RESET_LOW; k <= REG_CONVERT_WAIT; k++)
			write_reg(k[2:0], k[0] ? 16'd0 : 16'd1);

		// directed temperature, sender holds off during the conversion wait
		// until all results are back
		run_read(16'h07d0, 1'b1, 1'b0, 1'b1);
		// negative reading with no sensor answering, sequence still runs
		run_read(16'hfc90, 1'b0, 1'b0, 1'b0);
		settle();

		// one random read under each idling mix
		for (p = 0; p < 4; p++) begin
			send_gap_pct   = (p == 1) ? 58 : (p == 3) ? 17 : 0;
			recv_stall_pct = (p == 2) ? 58 : (p == 3) ? 17 : 0;
			settle();
			for (k = REG_RESET_LOW; k <= REG_CONVERT_WAIT; k++)
				write_reg(k[2:0], ($urandom_range(7) == 0) ?
					16'($urandom_range(2, 4)) : 16'($urandom_range(0, 1)));
			// disabled reads with junk in the upper data bits
			if ($urandom_range(4) == 0) begin
				write_reg(REG_READ_ENABLE, {15'($urandom), 1'b0});
				repeat (3) push_tick(1'b1, 1'($urandom_range(1)));
				settle();
				write_reg(REG_READ_ENABLE, {15'($urandom), 1'b1});
			end
			repeat ($urandom_range(4)) push_tick(1'b0, 1'($urandom_range(1)));
			raw = ($urandom_range(1) == 0) ? picks[$urandom_range(5)] :
				16'($urandom_range(0, 65535));
			run_read(raw, $urandom_range(7) != 0, $urandom_range(4) == 0, 1'b0);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_onewire_temperature_reader: done, clean");
		else
			$display("tb_onewire_temperature_reader: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("tb_onewire_temperature_reader: done, errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/owt_pkg.sv
design/owt_cfg.sv
design/owt_core.sv
design/onewire_temperature_reader.sv
design/owt_checker.sv
sim/tb_onewire_temperature_reader.sv
